[hdl/hrlt_pkg.sv]
// Shared types and constants for the HTTP request line tokenizer.
package hrlt_pkg;

    // Depth of the result queue; it must hold at least two results.
    localparam int RESULT_FIFO_DEPTH = 4;

    // Characters the tokenizer reacts to.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Field kinds carried with each content byte.
    localparam logic [2:0] KIND_METHOD  = 3'd0;
    localparam logic [2:0] KIND_PATH    = 3'd1;
    localparam logic [2:0] KIND_QNAME   = 3'd2;
    localparam logic [2:0] KIND_VERSION = 3'd4;

    // Line status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LOC = 2'd1;
    localparam logic [1:0] ST_BAD_REQ = 2'd2;

    // Bits of the seen-parts mask.
    localparam logic [2:0] SEEN_METHOD  = 3'b001;
    localparam logic [2:0] SEEN_PATH    = 3'b010;
    localparam logic [2:0] SEEN_VERSION = 3'b100;
    localparam logic [2:0] SEEN_ALL     = 3'b111;

    // Percent escape progress.
    typedef enum logic [1:0] {
        HEX_NONE = 2'd0,
        HEX_PCT  = 2'd1,
        HEX_ONE  = 2'd2
    } hex_state_t;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_SKIP1   = 3'd1,
        PH_PATH    = 3'd2,
        PH_QUERY   = 3'd3,
        PH_SKIP2   = 3'd4,
        PH_VERSION = 3'd5
    } phase_t;

    // One result item; byte_valid sits in the lowest bit.
    typedef struct packed {
        logic       last_of_run;
        logic       line_done;
        logic [1:0] status;
        logic       pair_end;
        logic [2:0] field_kind;
        logic [7:0] out_byte;
        logic       byte_valid;
    } result_t;

    // Everything one processed byte produces.
    typedef struct packed {
        logic    extra_valid;
        result_t extra;
        result_t main;
    } hrlt_out_t;

endpackage

[hdl/http_request_line_tokenizer.sv]
// Top level of the HTTP request line tokenizer: input register, tokenizer core, result queue.
// Each accepted byte waits in the input register until the result queue has room for two
// results; it is then decoded, and its first result is offered on m_tvalid from the queue.
// Throughput: one byte per cycle while each byte yields one result and the queue has room;
// a byte that flushes a held escape digit yields two results, and the input waits whenever
// the result queue cannot take two more results.
// Reset: aresetn is synchronous and active low; it drops all held bytes and queued results
// and puts the tokenizer back at the start of a line.
module http_request_line_tokenizer import hrlt_pkg::*; #(
    parameter int ResultDepth = RESULT_FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream: one raw byte of the request line per item.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_line
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] pair_end, [10:9] status,
                                   // [11] line_done, [15:12] zero
    output logic [3:0]  m_tuser,   // [0] byte_valid, [3:1] field_kind
    output logic        m_tlast    // last_of_run
);

    // The input register decouples the upstream handshake from the decision logic.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eol_reg;

    logic       proc_fire;
    logic       room_two;
    hrlt_out_t  core_res;
    result_t    head;

    // A byte is decoded only when the queue can take both of its possible results.
    assign proc_fire = in_valid_reg && room_two;
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_eol_reg  <= s_tlast;
        end
    end

    // The core holds the line state and decides the results of the held byte.
    hrlt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc_en (proc_fire),
        .in_byte (in_byte_reg),
        .in_eol  (in_eol_reg),
        .res     (core_res)
    );

    // When a held escape digit is flushed, it is queued ahead of the byte's own result.
    hrlt_result_fifo #(
        .Depth (ResultDepth)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (proc_fire),
        .wr_two   (core_res.extra_valid),
        .wr_data0 (core_res.extra_valid ? core_res.extra : core_res.main),
        .wr_data1 (core_res.main),
        .room_two (room_two),
        .rd_en    (m_tready),
        .rd_valid (m_tvalid),
        .rd_data  (head)
    );

    assign m_tdata = {4'd0, head.line_done, head.status, head.pair_end, head.out_byte};
    assign m_tuser = {head.field_kind, head.byte_valid};
    assign m_tlast = head.last_of_run;

    // A flushed escape digit is always content and never ends the byte's run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && core_res.extra_valid |->
            core_res.extra.byte_valid && !core_res.extra.last_of_run)
        else $error("flushed escape result malformed");

    // The byte's own result marks the line end exactly when the byte does.
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire |-> core_res.main.last_of_run && (core_res.main.line_done == in_eol_reg))
        else $error("own result framing wrong");

    // A line-done result always closes its byte's run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> m_tlast)
        else $error("line_done on a result that is not last of run");

    // A byte waiting for queue space is kept unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !proc_fire |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_eol_reg))
        else $error("held byte lost while stalled");

endmodule

[hdl/hrlt_core.sv]
// Tokenizer state and the per-byte decision logic.
module hrlt_core import hrlt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       proc_en,
    input  logic [7:0] in_byte,
    input  logic       in_eol,
    output hrlt_out_t  res
);

    phase_t     phase_reg, phase_next, work_phase;
    logic       in_value_reg, in_value_next;
    logic       prev_dot_reg, prev_dot_next;
    hex_state_t hex_reg, hex_next;
    logic [3:0] hexv_reg, hexv_next;
    logic [2:0] seen_reg, seen_next;
    logic [1:0] err_reg, err_next;

    logic       is_hex;
    logic [3:0] digit;
    logic       consumed;
    logic       r_valid;
    logic [7:0] r_byte;
    logic [2:0] r_kind;
    logic       r_pair;
    logic       x_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_METHOD;
            in_value_reg <= 1'b0;
            prev_dot_reg <= 1'b0;
            hex_reg      <= HEX_NONE;
            hexv_reg     <= 4'd0;
            seen_reg     <= 3'd0;
            err_reg      <= ST_OK;
        end else if (proc_en) begin
            phase_reg    <= phase_next;
            in_value_reg <= in_value_next;
            prev_dot_reg <= prev_dot_next;
            hex_reg      <= hex_next;
            hexv_reg     <= hexv_next;
            seen_reg     <= seen_next;
            err_reg      <= err_next;
        end
    end

    // Uppercase hex only; the digit value is meaningful only when is_hex is set.
    assign is_hex = (in_byte >= 8'h30 && in_byte <= 8'h39) ||
                    (in_byte >= 8'h41 && in_byte <= 8'h46);
    assign digit  = (in_byte <= 8'h39) ? in_byte[3:0] : in_byte[3:0] + 4'd9;

    always_comb begin
        phase_next    = phase_reg;
        work_phase    = phase_reg;
        in_value_next = in_value_reg;
        prev_dot_next = prev_dot_reg;
        hex_next      = hex_reg;
        hexv_next     = hexv_reg;
        seen_next     = seen_reg;
        err_next      = err_reg;
        consumed      = 1'b0;
        r_valid       = 1'b0;
        r_byte        = 8'd0;
        r_kind        = KIND_METHOD;
        r_pair        = 1'b0;
        x_valid       = 1'b0;

        if (err_reg == ST_OK) begin
            // A non-space byte ends a run of separator spaces.
            if (phase_reg == PH_SKIP1 && in_byte != CH_SPACE) begin
                work_phase = PH_PATH;
            end else if (phase_reg == PH_SKIP2 && in_byte != CH_SPACE) begin
                work_phase = PH_VERSION;
            end
            phase_next = work_phase;

            unique case (work_phase)
                PH_METHOD: begin
                    if (in_byte == CH_SPACE) begin
                        phase_next = PH_SKIP1;
                    end else begin
                        r_valid   = 1'b1;
                        r_byte    = in_byte;
                        r_kind    = KIND_METHOD;
                        seen_next = seen_reg | SEEN_METHOD;
                    end
                end
                PH_PATH: begin
                    if (in_byte == CH_SPACE) begin
                        phase_next = PH_SKIP2;
                    end else if (in_byte == CH_QMARK) begin
                        phase_next    = PH_QUERY;
                        in_value_next = 1'b0;
                        hex_next      = HEX_NONE;
                    end else if (in_byte == CH_SLASH && prev_dot_reg) begin
                        err_next = ST_BAD_LOC;
                    end else begin
                        r_valid   = 1'b1;
                        r_byte    = in_byte;
                        r_kind    = KIND_PATH;
                        seen_next = seen_reg | SEEN_PATH;
                    end
                    prev_dot_next = (in_byte == CH_DOT);
                end
                PH_QUERY: begin
                    if (hex_reg == HEX_PCT) begin
                        if (is_hex) begin
                            hexv_next = digit;
                            hex_next  = HEX_ONE;
                            consumed  = 1'b1;
                        end else begin
                            // A bare percent sign is simply dropped.
                            hex_next = HEX_NONE;
                        end
                    end else if (hex_reg == HEX_ONE) begin
                        if (is_hex) begin
                            r_valid  = 1'b1;
                            r_byte   = {hexv_reg, digit};
                            r_kind   = {2'b01, in_value_reg};
                            consumed = 1'b1;
                        end else begin
                            // The held single digit goes out ahead of this byte.
                            x_valid = 1'b1;
                        end
                        hex_next = HEX_NONE;
                    end
                    if (!consumed) begin
                        if (in_byte == CH_SPACE) begin
                            r_pair     = 1'b1;
                            phase_next = PH_SKIP2;
                        end else if (in_byte == CH_PCT) begin
                            hex_next = HEX_PCT;
                        end else if (in_byte == CH_EQ || in_byte == CH_AMP) begin
                            if (in_value_reg) begin
                                r_pair        = 1'b1;
                                in_value_next = 1'b0;
                            end else begin
                                in_value_next = 1'b1;
                            end
                        end else begin
                            r_valid = 1'b1;
                            r_byte  = in_byte;
                            r_kind  = {2'b01, in_value_reg};
                        end
                    end
                    // The line ends inside the query: flush a held digit, close the pair.
                    if (in_eol && phase_next == PH_QUERY) begin
                        if (hex_next == HEX_ONE) begin
                            r_valid = 1'b1;
                            r_byte  = {4'd0, hexv_next};
                            r_kind  = {2'b01, in_value_next};
                        end
                        r_pair = 1'b1;
                    end
                end
                PH_VERSION: begin
                    r_valid   = 1'b1;
                    r_byte    = in_byte;
                    r_kind    = KIND_VERSION;
                    seen_next = seen_reg | SEEN_VERSION;
                end
                default: begin
                end
            endcase

            if (in_eol && err_next == ST_OK && seen_next != SEEN_ALL) begin
                err_next = ST_BAD_REQ;
            end
        end

        res.extra_valid       = x_valid;
        res.extra.byte_valid  = 1'b1;
        res.extra.out_byte    = {4'd0, hexv_reg};
        res.extra.field_kind  = {2'b01, in_value_reg};
        res.extra.pair_end    = 1'b0;
        res.extra.status      = ST_OK;
        res.extra.line_done   = 1'b0;
        res.extra.last_of_run = 1'b0;

        res.main.byte_valid   = r_valid;
        res.main.out_byte     = r_byte;
        res.main.field_kind   = r_kind;
        res.main.pair_end     = r_pair;
        res.main.status       = err_next;
        res.main.line_done    = in_eol;
        res.main.last_of_run  = 1'b1;

        // Every line starts from a clean state.
        if (in_eol) begin
            phase_next    = PH_METHOD;
            in_value_next = 1'b0;
            prev_dot_next = 1'b0;
            hex_next      = HEX_NONE;
            hexv_next     = 4'd0;
            seen_next     = 3'd0;
            err_next      = ST_OK;
        end
    end

endmodule

[hdl/hrlt_result_fifo.sv]
// Small result queue that takes one or two results a cycle and gives one.
module hrlt_result_fifo import hrlt_pkg::*; #(
    parameter int Depth = RESULT_FIFO_DEPTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_en,
    input  logic    wr_two,
    input  result_t wr_data0,
    input  result_t wr_data1,
    output logic    room_two,
    input  logic    rd_en,
    output logic    rd_valid,
    output result_t rd_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

    result_t         mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [PtrW-1:0] wr_addr1;
    logic [PtrW-1:0] wr_addr2;
    logic            do_rd;

    assign wr_addr1 = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
    assign wr_addr2 = (wr_addr1 == LastPtr) ? '0 : wr_addr1 + 1'b1;
    assign do_rd    = rd_en && (count_reg != '0);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign room_two = (count_reg <= CntW'(Depth - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = wr_two ? wr_addr2 : wr_addr1;
            count_next  = count_next + (wr_two ? CntW'(2) : CntW'(1));
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_next - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data0;
            if (wr_two) begin
                mem[wr_addr1] <= wr_data1;
            end
        end
    end

endmodule
